@@ rtl/sapq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and codes for the sorted-array priority queue: command and
// status codes, the stored entry layout and the controller state type.
// ----------------------------------------------------------------------------
package sapq_pkg;

    localparam int PRIO_W = 31;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 7;

    // Command codes carried by a request.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_CHANGE = 2'd2;

    // Status codes reported with every result.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    // One stored entry: priority in the upper bits, value in the lower bits.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [VAL_W-1:0]  value;
    } sapq_entry_t;

    localparam int ENTRY_W = $bits(sapq_entry_t);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_SHIFT_UP,
        ST_FIND,
        ST_SHIFT_DOWN,
        ST_HEAD,
        ST_RESPOND
    } sapq_state_t;

endpackage : sapq_pkg
`default_nettype wire

@@ rtl/sorted_array_priority_queue_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_core
// Priority queue that keeps (priority, value) entries sorted by ascending
// priority in one entry RAM. Insert, pop head and change priority commands.
// ----------------------------------------------------------------------------
// Usage:
// A request (cmd, value, priority_req) is taken when in_valid and in_ready
// are both high; in_ready is high only while the controller is idle, so one
// request is worked at a time. Each request yields exactly one result
// (status, head_value, head_priority, count, empty_res) on the out_valid /
// out_ready channel. The result sits in an output register, so the next
// request is accepted while a result waits; a stalled receiver only blocks
// the controller when a second result is ready to be written.
// The read port walks the store entry by entry: pop shifts the entries down,
// insert does a binary search and shifts the entries above the slot up, and
// change priority runs find and shift down (together one walk of the store),
// then search and shift up. Each shift moves one entry per cycle; each
// search step takes a SEARCH and a COMPARE state for the read latency.
// Reset empties the queue at once (entry count cleared); the RAM contents
// are not cleared, since entries at or above the count never reach a result.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_core #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic signed [sapq_pkg::VAL_W-1:0]  value,
    input  logic [sapq_pkg::PRIO_W-1:0]   priority_req,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic signed [sapq_pkg::VAL_W-1:0]  head_value,
    output logic [sapq_pkg::PRIO_W-1:0]   head_priority,
    output logic [sapq_pkg::CNT_W-1:0]    count,
    output logic                          empty_res
);

    import sapq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Controller and datapath registers.
    sapq_state_t       state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic [1:0]        stat_reg, stat_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     dst_reg, dst_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic              pend_reg, pend_next;

    // Result registers.
    logic              res_valid_reg, res_valid_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    logic [PRIO_W-1:0] res_prio_reg, res_prio_next;
    logic [CW-1:0]     res_count_reg, res_count_next;

    // RAM port signals.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    sapq_entry_t       ram_wentry;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    sapq_entry_t       rd_entry;

    // Helpers.
    logic [CW:0]       mid_sum;
    logic [CW-1:0]     mid_calc;
    logic              find_hit;
    logic              res_free;
    logic [CW+CNT_W-1:0] count_ext;

    assign rd_entry = ram_rdata;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[CW:1];
    assign find_hit = pend_reg && (rd_entry.value == val_reg);
    assign res_free = !res_valid_reg || out_ready;

    sapq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        CMD_INSERT:
                            state_next = (count_reg >= CW'(CAPACITY)) ? ST_HEAD : ST_SEARCH;
                        CMD_POP:
                            state_next = (count_reg == '0) ? ST_HEAD : ST_SHIFT_DOWN;
                        CMD_CHANGE:
                            state_next = ST_FIND;
                        default:
                            state_next = ST_HEAD;
                    endcase
                end
            end
            ST_SEARCH:
                state_next = (lo_reg < hi_reg) ? ST_COMPARE : ST_SHIFT_UP;
            ST_COMPARE:
                state_next = (rd_entry.prio == prio_reg) ? ST_SHIFT_UP : ST_SEARCH;
            ST_SHIFT_UP:
            begin
                if ((ptr_reg <= pos_reg) && !pend_reg)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_FIND:
            begin
                if (find_hit)
                begin
                    state_next = ST_SHIFT_DOWN;
                end
                else if ((ptr_reg >= count_reg) && !pend_reg)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_SHIFT_DOWN:
            begin
                if ((ptr_reg >= count_reg) && !pend_reg)
                begin
                    state_next = (cmd_reg == CMD_CHANGE) ? ST_SEARCH : ST_HEAD;
                end
            end
            ST_HEAD:
                state_next = ST_RESPOND;
            ST_RESPOND:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath, RAM control and result logic.
    always_comb
    begin
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        prio_next       = prio_reg;
        stat_next       = stat_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        ptr_next        = ptr_reg;
        dst_next        = dst_reg;
        pos_next        = pos_reg;
        pend_next       = 1'b0;
        res_valid_next  = res_valid_reg && !out_ready;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_prio_next   = res_prio_reg;
        res_count_next  = res_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = dst_reg[AW-1:0];
        ram_wentry      = rd_entry;
        ram_re          = 1'b0;
        ram_raddr       = ptr_reg[AW-1:0];
        in_ready        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd_next  = cmd;
                val_next  = value;
                prio_next = priority_req;
                stat_next = STAT_OK;
                lo_next   = '0;
                hi_next   = count_reg;
                ptr_next  = '0;
                if (in_valid)
                begin
                    case (cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                stat_next = STAT_FULL;
                            end
                        end
                        CMD_POP:
                        begin
                            ptr_next = CW'(1);
                            if (count_reg == '0)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Binary search: issue the midpoint read.
            ST_SEARCH:
            begin
                mid_next  = mid_calc;
                ram_re    = lo_reg < hi_reg;
                ram_raddr = mid_calc[AW-1:0];
                pos_next  = lo_reg;
                ptr_next  = count_reg;
            end

            // Binary search: narrow the range on the returned priority.
            ST_COMPARE:
            begin
                pos_next = mid_reg;
                ptr_next = count_reg;
                if (rd_entry.prio > prio_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + CW'(1);
                end
            end

            // Move entries above the slot up by one, then write the new entry.
            ST_SHIFT_UP:
            begin
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (ptr_reg > pos_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(ptr_reg - CW'(1));
                    dst_next  = ptr_reg;
                    ptr_next  = ptr_reg - CW'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = pos_reg[AW-1:0];
                    ram_wentry.prio  = prio_reg;
                    ram_wentry.value = val_reg;
                    count_next       = count_reg + CW'(1);
                end
            end

            // Linear search for the first entry holding the value.
            ST_FIND:
            begin
                if (find_hit)
                begin
                    ptr_next = dst_reg + CW'(1);
                end
                else if (ptr_reg < count_reg)
                begin
                    ram_re    = 1'b1;
                    dst_next  = ptr_reg;
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    stat_next = STAT_NOT_FOUND;
                end
            end

            // Move entries above the removed one down by one.
            ST_SHIFT_DOWN:
            begin
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (ptr_reg < count_reg)
                begin
                    ram_re    = 1'b1;
                    dst_next  = ptr_reg - CW'(1);
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    lo_next    = '0;
                    hi_next    = count_reg - CW'(1);
                end
            end

            // Read the head entry.
            ST_HEAD:
            begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end

            // Load the result register once it is free.
            ST_RESPOND:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = stat_reg;
                    res_count_next  = count_reg;
                    if (count_reg == '0)
                    begin
                        res_value_next = '0;
                        res_prio_next  = '0;
                    end
                    else
                    begin
                        res_value_next = rd_entry.value;
                        res_prio_next  = rd_entry.prio;
                    end
                end
            end

            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        prio_reg       <= prio_next;
        stat_reg       <= stat_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        ptr_reg        <= ptr_next;
        dst_reg        <= dst_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_prio_reg   <= res_prio_next;
        res_count_reg  <= res_count_next;
    end

    // Result ports.
    assign count_ext     = {{CNT_W{1'b0}}, res_count_reg};
    assign out_valid     = res_valid_reg;
    assign status        = res_status_reg;
    assign head_value    = res_value_reg;
    assign head_priority = res_prio_reg;
    assign count         = count_ext[CNT_W-1:0];
    assign empty_res     = (res_count_reg == '0);

endmodule : sorted_array_priority_queue_core
`default_nettype wire

@@ rtl/sapq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sapq_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. The read data holds while no read is issued.
// ----------------------------------------------------------------------------
module sapq_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : sapq_ram
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_array_priority_queue_core. A queue of
// requests feeds a valid/ready driver; every accepted request is applied to
// a shadow copy of the sorted store, and each result from the block is
// checked field by field against the queue state predicted for it.
// ----------------------------------------------------------------------------
module tb;

    import sapq_pkg::*;

    localparam int DEPTH          = 64;
    localparam int HOLD_LEN       = 400;
    localparam int TAIL_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 30;

    // The one command code that the block leaves unused.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};

    typedef struct {
        logic [1:0]        cmd;
        logic [VAL_W-1:0]  value;
        logic [PRIO_W-1:0] prio;
    } request_t;

    typedef struct {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] head_value;
        logic [PRIO_W-1:0]       head_priority;
        logic [CNT_W-1:0]        count;
        logic                    empty_res;
    } queue_view_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               cmd = CMD_INSERT;
    logic signed [VAL_W-1:0]  value = '0;
    logic [PRIO_W-1:0]        priority_req = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [1:0]               status;
    logic signed [VAL_W-1:0]  head_value;
    logic [PRIO_W-1:0]        head_priority;
    logic [CNT_W-1:0]         count;
    logic                     empty_res;

    // Shadow of the sorted store, kept in step with accepted requests.
    logic [PRIO_W-1:0] shadow_prio [DEPTH];
    logic [VAL_W-1:0]  shadow_val  [DEPTH];
    int unsigned       shadow_count = 0;
    int unsigned       peak_count = 0;

    request_t    request_q[$];
    queue_view_t predicted_views[$];

    int n_offered = 0;
    int n_accepted = 0;
    int n_results = 0;
    int error_count = 0;
    int stall_cycles = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  pressure_on = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_cycles = 0;

    sorted_array_priority_queue_core #(
        .CAPACITY(DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .value        (value),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .head_value   (head_value),
        .head_priority(head_priority),
        .count        (count),
        .empty_res    (empty_res)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Binary search for the insert slot; stops at the first equal midpoint.
    function automatic int unsigned locate_slot(input logic [PRIO_W-1:0] p);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = shadow_count;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (shadow_prio[mid] == p)
                return mid;
            if (shadow_prio[mid] > p)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic void insert_entry(input logic [VAL_W-1:0] v,
                                         input logic [PRIO_W-1:0] p);
        int unsigned pos;
        pos = locate_slot(p);
        for (int unsigned i = shadow_count; i > pos; i--)
        begin
            shadow_prio[i] = shadow_prio[i-1];
            shadow_val[i]  = shadow_val[i-1];
        end
        shadow_prio[pos] = p;
        shadow_val[pos]  = v;
        shadow_count++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
    endfunction

    function automatic void remove_entry(input int unsigned pos);
        for (int unsigned i = pos; i + 1 < shadow_count; i++)
        begin
            shadow_prio[i] = shadow_prio[i+1];
            shadow_val[i]  = shadow_val[i+1];
        end
        shadow_count--;
    endfunction

    // Runs one request on the shadow store and returns the view it reports.
    function automatic queue_view_t apply_request(input logic [1:0] c,
                                                  input logic [VAL_W-1:0] v,
                                                  input logic [PRIO_W-1:0] p);
        queue_view_t view;
        int unsigned hit;
        bit          found;
        view.status = STAT_OK;
        found = 1'b0;
        hit = 0;
        case (c)
            CMD_INSERT:
            begin
                if (shadow_count >= DEPTH)
                    view.status = STAT_FULL;
                else
                    insert_entry(v, p);
            end
            CMD_POP:
            begin
                if (shadow_count == 0)
                    view.status = STAT_EMPTY;
                else
                    remove_entry(0);
            end
            CMD_CHANGE:
            begin
                // Only the first entry holding the value moves.
                for (int unsigned i = 0; i < shadow_count && !found; i++)
                begin
                    if (shadow_val[i] == v)
                    begin
                        found = 1'b1;
                        hit = i;
                    end
                end
                if (found)
                begin
                    remove_entry(hit);
                    insert_entry(v, p);
                end
                else
                    view.status = STAT_NOT_FOUND;
            end
            default:
            begin
                // Unused command: nothing changes.
            end
        endcase
        if (shadow_count > 0)
        begin
            view.head_value    = shadow_val[0];
            view.head_priority = shadow_prio[0];
            view.empty_res     = 1'b0;
        end
        else
        begin
            view.head_value    = '0;
            view.head_priority = '0;
            view.empty_res     = 1'b1;
        end
        view.count = shadow_count[CNT_W-1:0];
        status_tally[view.status]++;
        return view;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("ERROR: result %0d: %s, got %0h expected %0h",
                     n_results, what, got, want);
    endtask

    // Result checker, request tracker and watchdog, all on the rising edge.
    always @(posedge clk)
    begin : check_results
        queue_view_t want;
        bit          moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                n_results++;
                if (predicted_views.size() == 0)
                    report_mismatch("result with no request outstanding", 0, 0);
                else
                begin
                    want = predicted_views.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (head_value !== want.head_value)
                        report_mismatch("head_value", head_value, want.head_value);
                    if (head_priority !== want.head_priority)
                        report_mismatch("head_priority", head_priority,
                                        want.head_priority);
                    if (count !== want.count)
                        report_mismatch("count", count, want.count);
                    if (empty_res !== want.empty_res)
                        report_mismatch("empty_res", empty_res, want.empty_res);
                end
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                n_accepted++;
                predicted_views.push_back(apply_request(cmd, value, priority_req));
            end
            if (moved)
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
                    $display("** sorted_array_priority_queue_core: FAILED **");
                    $finish;
                end
            end
        end
    end

    // Request driver: holds each request until taken, idles at random.
    always @(negedge clk)
    begin : drive_requests
        request_t next_req;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || n_accepted == n_offered)
        begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = request_q.pop_front();
                cmd          <= next_req.cmd;
                value        <= next_req.value;
                priority_req <= next_req.prio;
                in_valid     <= 1'b1;
                n_offered++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus one long hold-off to back up the block.
    always @(negedge clk)
    begin
        if (pressure_on && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= HOLD_LEN)
                hold_done = 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic add_request(input logic [1:0] c, input logic [VAL_W-1:0] v,
                               input logic [PRIO_W-1:0] p);
        request_t r;
        r.cmd = c;
        r.value = v;
        r.prio = p;
        request_q.push_back(r);
    endtask

    // Waits until every request is taken and every result has come back.
    task automatic wait_for_drain();
        while (request_q.size() != 0 || n_accepted != n_offered ||
               predicted_views.size() != 0)
            @(posedge clk);
    endtask

    // Random traffic that swings between filling and draining the queue.
    // Values come mostly from a small pool so that change priority finds
    // matches and repeated values occur.
    task automatic run_random_phase(input int n_items, input int send_pct,
                                    input int recv_pct);
        int          roll;
        bit          filling;
        logic [1:0]  c;
        logic [VAL_W-1:0]  v;
        logic [PRIO_W-1:0] p;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < n_items; i++)
        begin
            filling = ((i / 120) % 2) == 0;
            roll = $urandom_range(99);
            if (filling)
                c = (roll < 72) ? CMD_INSERT : (roll < 84) ? CMD_POP :
                    (roll < 97) ? CMD_CHANGE : CMD_UNUSED;
            else
                c = (roll < 20) ? CMD_INSERT : (roll < 85) ? CMD_POP :
                    (roll < 97) ? CMD_CHANGE : CMD_UNUSED;
            if ($urandom_range(3) == 0)
                v = $urandom;
            else
                v = VAL_W'($urandom_range(15)) - VAL_W'(8);
            roll = $urandom_range(9);
            if (roll == 0)
                p = PRIO_W'($urandom);
            else if (roll == 1)
                case ($urandom_range(2))
                    0:       p = '0;
                    1:       p = PRIO_W'(1);
                    default: p = PRIO_MAX;
                endcase
            else
                p = PRIO_W'($urandom_range(24, 1));
            add_request(c, v, p);
        end
        wait_for_drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases, field extremes, ties, first-match change.
        add_request(CMD_POP, 32'sd0, PRIO_W'(1));
        add_request(CMD_CHANGE, 32'sd7, PRIO_W'(3));
        add_request(CMD_UNUSED, '1, PRIO_MAX);
        add_request(CMD_INSERT, 32'h7FFF_FFFF, PRIO_MAX);
        add_request(CMD_INSERT, 32'h8000_0000, PRIO_W'(1));
        add_request(CMD_INSERT, 32'h0000_0000, '0);
        add_request(CMD_INSERT, 32'hFFFF_FFFF, PRIO_W'(5));
        add_request(CMD_INSERT, 32'sd5, PRIO_W'(5));
        add_request(CMD_INSERT, 32'sd5, PRIO_W'(3));
        add_request(CMD_INSERT, 32'sd9, PRIO_W'(5));
        add_request(CMD_CHANGE, 32'sd5, PRIO_MAX);
        add_request(CMD_CHANGE, 32'sd12345, PRIO_W'(7));
        add_request(CMD_UNUSED, 32'h5555_AAAA, PRIO_W'(9));
        add_request(CMD_CHANGE, 32'h0000_0000, PRIO_W'(6));
        add_request(CMD_CHANGE, 32'h8000_0000, '0);
        for (int i = 0; i < 8; i++)
            add_request(CMD_POP, '1, PRIO_MAX);
        add_request(CMD_CHANGE, 32'sd5, PRIO_W'(2));
        wait_for_drain();

        // The first random phase opens with the long receiver hold-off.
        pressure_on = 1'b1;
        run_random_phase(500, 0, 0);
        run_random_phase(500, 87, 0);
        run_random_phase(500, 0, 87);
        run_random_phase(500, 23, 23);

        repeat (TAIL_CYCLES) @(posedge clk);
        while (predicted_views.size() != 0)
        begin
            void'(predicted_views.pop_front());
            report_mismatch("result never arrived", 0, 0);
        end

        $display("Ran %0d requests and checked %0d results; peak depth %0d.",
                 n_accepted, n_results, peak_count);
        $display("Status seen: %0d ok, %0d full, %0d empty, %0d not found; %0d errors.",
                 status_tally[STAT_OK], status_tally[STAT_FULL],
                 status_tally[STAT_EMPTY], status_tally[STAT_NOT_FOUND],
                 error_count);
        if (error_count == 0)
            $display("** sorted_array_priority_queue_core: PASSED **");
        else
            $display("** sorted_array_priority_queue_core: FAILED **");
        $finish;
    end

endmodule
